[hw/rtl/wrms_pkg.sv]
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared types and constants for the wildcard row match search block.
// ----------------------------------------------------------------------------
package wrms_pkg;

	localparam int DEF_TABLE_ROWS  = 64;
	localparam int DEF_NUM_COLUMNS = 8;
	localparam int DEF_CODE_BITS   = 8;

	localparam int FIELD_CODE_BITS = 8;
	localparam int VALUE_BITS      = 64;
	localparam int MISS_BITS       = 8;
	localparam int INDEX_BITS      = 6;
	localparam int CMD_BITS        = 2;
	localparam int CFG_COLS_BITS   = 4;
	localparam int APB_ADDR_BITS   = 3;
	localparam int APB_DATA_BITS   = 32;

	localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd2;

	localparam logic [APB_ADDR_BITS-3:0] REG_COLUMNS_IN_USE = 1'd0;

	typedef struct packed {
		logic [CMD_BITS-1:0]   cmd;
		logic [VALUE_BITS-1:0] row_values;
		logic [MISS_BITS-1:0]  row_missing;
	} in_item_t;

	typedef struct packed {
		logic                  matched;
		logic [INDEX_BITS-1:0] match_index;
		logic                  last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic capture_query;
		logic clear_table;
		logic load_row;
		logic issue_read;
		logic emit_final;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic last_read;
	} dp_status_t;

endpackage

[hw/rtl/wrms_ram.sv]
// ----------------------------------------------------------------------------
// wrms_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wrms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/wrms_ctrl.sv]
// ----------------------------------------------------------------------------
// wrms_ctrl
// Command sequencer: accepts commands and steps the datapath through a scan.
// ----------------------------------------------------------------------------
module wrms_ctrl
	import wrms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CMD_BITS-1:0] cmd,
	input  dp_status_t          status,
	output dp_cmd_t             dp_cmd,
	output logic                busy
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_QUERY)) begin
					state_d = status.empty ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.last_read) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dp_cmd = '0;
		busy   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy                 = 1'b0;
				dp_cmd.capture_query = accept && (cmd == CMD_QUERY);
				dp_cmd.clear_table   = accept && (cmd == CMD_CLEAR);
				dp_cmd.load_row      = accept && (cmd == CMD_LOAD);
			end
			ST_SCAN:  dp_cmd.issue_read = 1'b1;
			ST_DRAIN: dp_cmd            = '0;
			ST_FLUSH: dp_cmd.emit_final = 1'b1;
			default:  dp_cmd            = '0;
		endcase
	end

endmodule

[hw/rtl/wrms_dp.sv]
// ----------------------------------------------------------------------------
// wrms_dp
// Row table, row counter, scan address, column compare and result buffer.
// ----------------------------------------------------------------------------
module wrms_dp
	import wrms_pkg::*;
#(
	parameter int TABLE_ROWS  = DEF_TABLE_ROWS,
	parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
	parameter int CODE_BITS   = DEF_CODE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  in_item_t                 item,
	input  logic [CFG_COLS_BITS-1:0] columns_in_use,
	input  dp_cmd_t                  dp_cmd,
	output dp_status_t               status,
	output out_item_t                result,
	output logic                     result_valid
);

	localparam int IDX_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int CNT_W  = $clog2(TABLE_ROWS + 1);
	localparam int VAL_W  = NUM_COLUMNS * CODE_BITS;
	localparam int ROW_W  = VAL_W + NUM_COLUMNS;

	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       scan_q;
	logic [IDX_W-1:0]       index_s1;
	logic                   valid_s1;
	logic [VAL_W-1:0]       qval_q;
	logic [NUM_COLUMNS-1:0] qmiss_q;
	logic [IDX_W-1:0]       pend_idx_q;
	logic                   pend_valid_q;
	out_item_t              result_q;
	logic                   result_valid_q;

	logic [VAL_W-1:0]       in_val;
	logic [ROW_W-1:0]       wr_row;
	logic [ROW_W-1:0]       rd_row;
	logic [VAL_W-1:0]       sval;
	logic [NUM_COLUMNS-1:0] smiss;
	logic [NUM_COLUMNS-1:0] col_diff;
	logic                   full;
	logic                   hit;
	logic                   emit_hit;

	for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_col
		assign in_val[c*CODE_BITS +: CODE_BITS] =
			item.row_values[c*FIELD_CODE_BITS +: CODE_BITS];
		assign col_diff[c] = (CFG_COLS_BITS'(c) < columns_in_use) && !smiss[c] && !qmiss_q[c]
			&& (sval[c*CODE_BITS +: CODE_BITS] != qval_q[c*CODE_BITS +: CODE_BITS]);
	end

	assign wr_row = {item.row_missing[NUM_COLUMNS-1:0], in_val};
	assign sval   = rd_row[VAL_W-1:0];
	assign smiss  = rd_row[ROW_W-1:VAL_W];
	assign hit    = valid_s1 && (col_diff == '0);
	assign full   = (count_q == CNT_W'(TABLE_ROWS));

	assign status.empty     = (count_q == '0);
	assign status.last_read = (CNT_W'(CNT_W'(scan_q) + CNT_W'(1)) == count_q);

	wrms_ram #(
		.WIDTH(ROW_W),
		.DEPTH(TABLE_ROWS)
	) u_table (
		.clk   (clk),
		.we    (dp_cmd.load_row && !full),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_row),
		.re    (dp_cmd.issue_read),
		.raddr (scan_q),
		.rdata (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.clear_table) begin
			count_q <= '0;
		end else if (dp_cmd.load_row && !full) begin
			count_q <= CNT_W'(count_q + CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			valid_s1 <= dp_cmd.issue_read;
			if (dp_cmd.capture_query) begin
				scan_q <= '0;
			end else if (dp_cmd.issue_read) begin
				scan_q <= IDX_W'(scan_q + IDX_W'(1));
			end
			if (dp_cmd.capture_query || dp_cmd.emit_final) begin
				pend_valid_q <= 1'b0;
			end else if (hit) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		index_s1 <= scan_q;
		if (dp_cmd.capture_query) begin
			qval_q  <= in_val;
			qmiss_q <= item.row_missing[NUM_COLUMNS-1:0];
		end
		if (hit) begin
			pend_idx_q <= index_s1;
		end
	end

	assign emit_hit = hit && pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit_hit || dp_cmd.emit_final;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_hit) begin
			result_q.matched     <= 1'b1;
			result_q.match_index <= INDEX_BITS'(pend_idx_q);
			result_q.last        <= 1'b0;
		end else if (dp_cmd.emit_final) begin
			result_q.matched     <= pend_valid_q;
			result_q.match_index <= pend_valid_q ? INDEX_BITS'(pend_idx_q) : '0;
			result_q.last        <= 1'b1;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

[hw/rtl/wildcard_row_match_search.sv]
// ----------------------------------------------------------------------------
// wildcard_row_match_search
// Row table with two-sided wildcard match search over stored rows.
// ----------------------------------------------------------------------------
// Clear and load leave busy low, and the next command may follow.
// A query holds busy through scan, drain and flush (flush alone on an empty
// table): one row is read from the table RAM and compared per cycle.
// Results cannot stall; each match is reported, held until the next match.
// The final result carries last and is valid in the same cycle busy falls.
// Reset empties the table and sets columns_in_use to NUM_COLUMNS.
module wildcard_row_match_search
	import wrms_pkg::*;
#(
	parameter int TABLE_ROWS  = DEF_TABLE_ROWS,
	parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
	parameter int CODE_BITS   = DEF_CODE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	input  in_item_t                 item,
	output out_item_t                result,
	output logic                     result_valid
);

	logic [CFG_COLS_BITS-1:0] cols_q;
	logic [CFG_COLS_BITS-1:0] cols_wr;
	logic                     reg_sel;
	dp_cmd_t                  dp_cmd;
	dp_status_t               status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == REG_COLUMNS_IN_USE);
	assign cols_wr = (pwdata[CFG_COLS_BITS-1:0] > CFG_COLS_BITS'(NUM_COLUMNS))
		? CFG_COLS_BITS'(NUM_COLUMNS) : pwdata[CFG_COLS_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_COLS_BITS'(NUM_COLUMNS);
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cols_q <= cols_wr;
		end
	end

	assign prdata = reg_sel ? APB_DATA_BITS'(cols_q) : '0;

	wrms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (item.cmd),
		.status (status),
		.dp_cmd (dp_cmd),
		.busy   (busy)
	);

	wrms_dp #(
		.TABLE_ROWS  (TABLE_ROWS),
		.NUM_COLUMNS (NUM_COLUMNS),
		.CODE_BITS   (CODE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.columns_in_use (cols_q),
		.dp_cmd         (dp_cmd),
		.status         (status),
		.result         (result),
		.result_valid   (result_valid)
	);

endmodule
